// ----- src/integer_range_set_table_assert.svh -----
// Assertion macros shared by the integer range set table sources.
// Each macro expands to a concurrent assertion clocked by clk and
// disabled while rst_n is low, or to nothing when SYNTH is defined.
`ifndef INTEGER_RANGE_SET_TABLE_ASSERT_SVH
`define INTEGER_RANGE_SET_TABLE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication: cons must hold whenever ante holds.
`define IRST_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("integer_range_set_table: implication check failed");
// Next-cycle implication: cons must hold in the cycle after ante.
`define IRST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("integer_range_set_table: next-cycle check failed");
`else
`define IRST_ASSERT_IMP(lbl, ante, cons)
`define IRST_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- src/irst_pkg.sv -----
package irst_pkg;

    localparam int FIELD_W = 16;
    localparam int INDEX_FIELD_W = 4;
    localparam int COUNT_W = 5;
    localparam int TOTAL_W = 17;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_QUERY  = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ORDER = 2'd1,
        ST_FULL  = 2'd2,
        ST_INDEX = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]               operation;
        logic [FIELD_W-1:0]       insert_begin;
        logic [FIELD_W-1:0]       insert_end;
        logic [FIELD_W-1:0]       query_value;
        logic [INDEX_FIELD_W-1:0] entry_index;
    } cmd_t;

    typedef struct packed {
        logic               hit;
        logic [FIELD_W-1:0] entry_begin;
        logic [FIELD_W-1:0] entry_end;
        logic [COUNT_W-1:0] range_count;
        logic [TOTAL_W-1:0] total_size;
        logic [1:0]         status;
    } rsp_t;

    // Movement of the cell chain for one cycle.
    typedef struct packed {
        logic pop;
        logic push;
    } cell_ctrl_t;

endpackage

// ----- src/irst_chan_if.sv -----
interface irst_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- src/integer_range_set_table.sv -----
// Integer range set table. The block keeps a set of integers as up to
// MAX_RUNS disjoint inclusive runs in ascending order, held in a row of
// cells that behaves as a queue: the head cell is examined by one compare
// unit each cycle, and runs leave at the head and re-enter at the tail.
// An insert streams the stored runs past the head once, passing runs below
// the new run straight through, absorbing runs that overlap or touch it,
// and writing the merged run back in order. A query or a read rotates the
// queue once. One transfer on cmd yields exactly one transfer on res, which
// waits in an output register so that the next command can be taken before
// the result is collected. When the table already holds MAX_RUNS runs,
// an insert first walks the table once more to check for room, and an
// insert that finds no room answers without a rebuild. An insert with
// begin above end, an out-of-range read, an unused operation and a query
// on an empty table answer without touching the queue. The time that a
// command takes is set by the single head-of-chain compare, which sees
// one stored run per cycle, except that a rebuild holds the head while it
// writes the new or merged run out ahead of a higher stored run. The
// block is ready for a new command in the cycle after the result is
// loaded into the output register. Values are taken modulo 2^VALUE_BITS;
// range_count and total_size are truncated to their field widths.
`include "integer_range_set_table_assert.svh"

module integer_range_set_table #(
    parameter int MAX_RUNS = 16,
    parameter int VALUE_BITS = 16
) (
    input logic            clk,
    input logic            rst_n,
    irst_chan_if.sink      cmd,
    irst_chan_if.source    res
);

    import irst_pkg::*;

    localparam int CNT_W = $clog2(MAX_RUNS + 1);
    localparam int IDX_W = $clog2(MAX_RUNS);
    localparam int SUM_W = VALUE_BITS + 1;
    localparam int CMP_W = CNT_W + INDEX_FIELD_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_RUNS);

    // S_WALK rotates the queue once for a query, a read or the room check
    // of an insert into a full table. S_BUILD rebuilds the table for an
    // insert. S_DONE waits until the output register is free.
    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_BUILD,
        S_DONE
    } fsm_state_t;

    // Where the insert stands relative to the stored runs seen so far.
    typedef enum logic [1:0] {
        PH_BELOW,
        PH_MERGE,
        PH_ABOVE
    } phase_t;

    fsm_state_t state_reg, state_next;
    phase_t     phase_reg, phase_next;

    logic [1:0]               op_reg, op_next;
    logic [VALUE_BITS-1:0]    beg_reg, beg_next;
    logic [VALUE_BITS-1:0]    end_reg, end_next;
    logic [VALUE_BITS-1:0]    qry_reg, qry_next;
    logic [INDEX_FIELD_W-1:0] idx_reg, idx_next;
    logic [VALUE_BITS-1:0]    mb_reg, mb_next;
    logic [VALUE_BITS-1:0]    me_reg, me_next;
    logic [CNT_W-1:0]         step_reg, step_next;
    logic [CNT_W-1:0]         len_reg, len_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [SUM_W-1:0]         total_reg, total_next;
    logic [SUM_W-1:0]         acc_reg, acc_next;
    logic                     merge_seen_reg, merge_seen_next;
    logic                     hit_reg, hit_next;
    logic [FIELD_W-1:0]       eb_reg, eb_next;
    logic [FIELD_W-1:0]       ee_reg, ee_next;
    status_t                  st_reg, st_next;
    logic                     res_valid_reg, res_valid_next;
    rsp_t                     res_reg, res_next;

    // Cell chain.
    logic [VALUE_BITS-1:0] cell_first [MAX_RUNS];
    logic [VALUE_BITS-1:0] cell_last  [MAX_RUNS];
    logic [VALUE_BITS-1:0] head_first;
    logic [VALUE_BITS-1:0] head_last;
    logic [VALUE_BITS-1:0] push_first;
    logic [VALUE_BITS-1:0] push_last;
    logic [IDX_W-1:0]      wpos;
    cell_ctrl_t            ctrl;

    // Decoded input fields and head comparisons.
    logic [VALUE_BITS-1:0] in_beg;
    logic [VALUE_BITS-1:0] in_end;
    logic                  head_below;
    logic                  head_touch;
    logic                  head_hit;
    logic                  last_step;
    logic                  commit;
    logic [SUM_W-1:0]      push_size;

    genvar k;
    generate
        for (k = 0; k < MAX_RUNS; k++)
        begin : g_cell
            if (k < MAX_RUNS - 1)
            begin : g_mid
                irst_cell #(
                    .VALUE_BITS (VALUE_BITS),
                    .IDX_W      (IDX_W),
                    .CELL_INDEX (k)
                ) u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl),
                    .wpos       (wpos),
                    .push_first (push_first),
                    .push_last  (push_last),
                    .next_first (cell_first[k+1]),
                    .next_last  (cell_last[k+1]),
                    .run_first  (cell_first[k]),
                    .run_last   (cell_last[k])
                );
            end
            else
            begin : g_tail
                // The tail cell has no neighbor; on a pop it keeps its run,
                // which becomes a stale entry beyond the queue length.
                irst_cell #(
                    .VALUE_BITS (VALUE_BITS),
                    .IDX_W      (IDX_W),
                    .CELL_INDEX (k)
                ) u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl),
                    .wpos       (wpos),
                    .push_first (push_first),
                    .push_last  (push_last),
                    .next_first (cell_first[k]),
                    .next_last  (cell_last[k]),
                    .run_first  (cell_first[k]),
                    .run_last   (cell_last[k])
                );
            end
        end
    endgenerate

    assign head_first = cell_first[0];
    assign head_last  = cell_last[0];

    // A pushed run lands just behind the last queued run, after the shift
    // when the head leaves in the same cycle.
    assign wpos = ctrl.pop ? IDX_W'(len_reg - 1'b1) : IDX_W'(len_reg);

    assign in_beg = VALUE_BITS'(cmd.payload.insert_begin);
    assign in_end = VALUE_BITS'(cmd.payload.insert_end);

    // The head run lies wholly below the new run and does not touch it.
    assign head_below = (SUM_W'(head_last) + SUM_W'(1)) < SUM_W'(beg_reg);
    // The head run starts no later than one past the new run's end.
    assign head_touch = SUM_W'(head_first) <= (SUM_W'(end_reg) + SUM_W'(1));
    assign head_hit   = (qry_reg >= head_first) && (qry_reg <= head_last);
    assign last_step  = (step_reg == (count_reg - 1'b1));

    assign push_size = SUM_W'(push_last) - SUM_W'(push_first) + SUM_W'(1);

    assign cmd.ready = (state_reg == S_IDLE);
    assign res.valid = res_valid_reg;
    assign res.payload = res_reg;

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        op_next         = op_reg;
        beg_next        = beg_reg;
        end_next        = end_reg;
        qry_next        = qry_reg;
        idx_next        = idx_reg;
        mb_next         = mb_reg;
        me_next         = me_reg;
        step_next       = step_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        acc_next        = acc_reg;
        merge_seen_next = merge_seen_reg;
        hit_next        = hit_reg;
        eb_next         = eb_reg;
        ee_next         = ee_reg;
        st_next         = st_reg;
        res_valid_next  = res_valid_reg;
        res_next        = res_reg;
        ctrl            = '0;
        push_first      = head_first;
        push_last       = head_last;
        commit          = 1'b0;

        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next         = cmd.payload.operation;
                    beg_next        = in_beg;
                    end_next        = in_end;
                    qry_next        = VALUE_BITS'(cmd.payload.query_value);
                    idx_next        = cmd.payload.entry_index;
                    mb_next         = in_beg;
                    me_next         = in_end;
                    step_next       = '0;
                    acc_next        = '0;
                    merge_seen_next = 1'b0;
                    phase_next      = PH_BELOW;
                    hit_next        = 1'b0;
                    eb_next         = '0;
                    ee_next         = '0;
                    st_next         = ST_OK;
                    state_next      = S_DONE;
                    case (cmd.payload.operation)
                        OP_INSERT:
                        begin
                            if (in_beg > in_end)
                            begin
                                st_next = ST_ORDER;
                            end
                            else if (count_reg == FULL_COUNT)
                            begin
                                // A full table has room only if something merges.
                                state_next = S_WALK;
                            end
                            else
                            begin
                                state_next = S_BUILD;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = S_WALK;
                            end
                        end
                        OP_READ:
                        begin
                            if (CMP_W'(cmd.payload.entry_index) >= CMP_W'(count_reg))
                            begin
                                st_next = ST_INDEX;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                            st_next = ST_OK;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                // Rotate the head run to the tail; after count steps the
                // queue is back in its original order.
                ctrl.pop  = 1'b1;
                ctrl.push = 1'b1;
                step_next = step_reg + 1'b1;
                case (op_reg)
                    OP_QUERY:
                    begin
                        if (head_hit)
                        begin
                            hit_next = 1'b1;
                        end
                    end
                    OP_READ:
                    begin
                        if (CMP_W'(idx_reg) == CMP_W'(step_reg))
                        begin
                            eb_next = FIELD_W'(head_first);
                            ee_next = FIELD_W'(head_last);
                        end
                    end
                    OP_INSERT:
                    begin
                        if (!head_below && head_touch)
                        begin
                            merge_seen_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        hit_next = 1'b0;
                    end
                endcase
                if (last_step)
                begin
                    state_next = S_DONE;
                    if (op_reg == OP_INSERT)
                    begin
                        if (merge_seen_reg || (!head_below && head_touch))
                        begin
                            state_next = S_BUILD;
                            step_next  = '0;
                        end
                        else
                        begin
                            st_next = ST_FULL;
                        end
                    end
                end
            end

            S_BUILD:
            begin
                if (step_reg == count_reg)
                begin
                    // Every stored run has been seen; emit the merged run
                    // unless it already went out ahead of a higher run.
                    if (phase_reg != PH_ABOVE)
                    begin
                        ctrl.push  = 1'b1;
                        push_first = mb_reg;
                        push_last  = me_reg;
                    end
                    commit     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    case (phase_reg)
                        PH_BELOW:
                        begin
                            if (head_below)
                            begin
                                ctrl.pop  = 1'b1;
                                ctrl.push = 1'b1;
                                step_next = step_reg + 1'b1;
                            end
                            else if (head_touch)
                            begin
                                // First run that merges: absorb it.
                                ctrl.pop   = 1'b1;
                                step_next  = step_reg + 1'b1;
                                mb_next    = (head_first < beg_reg) ? head_first : beg_reg;
                                me_next    = (head_last > end_reg) ? head_last : end_reg;
                                phase_next = PH_MERGE;
                            end
                            else
                            begin
                                // The new run fits in a gap: emit it and
                                // keep the head for the next cycle.
                                ctrl.push  = 1'b1;
                                push_first = beg_reg;
                                push_last  = end_reg;
                                phase_next = PH_ABOVE;
                            end
                        end
                        PH_MERGE:
                        begin
                            if (head_touch)
                            begin
                                ctrl.pop  = 1'b1;
                                step_next = step_reg + 1'b1;
                                if (head_last > me_reg)
                                begin
                                    me_next = head_last;
                                end
                            end
                            else
                            begin
                                ctrl.push  = 1'b1;
                                push_first = mb_reg;
                                push_last  = me_reg;
                                phase_next = PH_ABOVE;
                            end
                        end
                        PH_ABOVE:
                        begin
                            ctrl.pop  = 1'b1;
                            ctrl.push = 1'b1;
                            step_next = step_reg + 1'b1;
                        end
                        default:
                        begin
                            phase_next = PH_ABOVE;
                        end
                    endcase
                end
            end

            S_DONE:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next       = 1'b1;
                    res_next.hit         = hit_reg;
                    res_next.entry_begin = eb_reg;
                    res_next.entry_end   = ee_reg;
                    res_next.range_count = COUNT_W'(count_reg);
                    res_next.total_size  = TOTAL_W'(total_reg);
                    res_next.status      = st_reg;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // The covered total of the new table grows with each run written
        // during a rebuild.
        if ((state_reg == S_BUILD) && ctrl.push)
        begin
            acc_next = acc_reg + push_size;
        end

        len_next = len_reg + CNT_W'(ctrl.push) - CNT_W'(ctrl.pop);

        if (commit)
        begin
            count_next = len_next;
            total_next = acc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_BELOW;
            step_reg      <= '0;
            len_reg       <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            len_reg       <= len_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        beg_reg        <= beg_next;
        end_reg        <= end_next;
        qry_reg        <= qry_next;
        idx_reg        <= idx_next;
        mb_reg         <= mb_next;
        me_reg         <= me_next;
        acc_reg        <= acc_next;
        merge_seen_reg <= merge_seen_next;
        hit_reg        <= hit_next;
        eb_reg         <= eb_next;
        ee_reg         <= ee_next;
        st_reg         <= st_next;
    end

    // Between commands the queue holds exactly the stored runs.
    `IRST_ASSERT_IMP(a_idle_len, state_reg == S_IDLE, len_reg == count_reg)
    // The head never leaves an empty queue.
    `IRST_ASSERT_IMP(a_pop_nonempty, ctrl.pop, len_reg != '0)
    // A push without a pop always finds a free cell.
    `IRST_ASSERT_IMP(a_push_room, ctrl.push && !ctrl.pop, len_reg < FULL_COUNT)
    // A table-full result is only given for a table that is full.
    `IRST_ASSERT_IMP(a_full_count, state_reg == S_DONE && st_reg == ST_FULL, count_reg == FULL_COUNT)
    // A command transfer always starts work.
    `IRST_ASSERT_NEXT(a_cmd_leaves_idle, cmd.valid && cmd.ready, state_reg != S_IDLE)

endmodule

// ----- src/irst_cell.sv -----
module irst_cell #(
    parameter int VALUE_BITS = 16,
    parameter int IDX_W = 4,
    parameter int CELL_INDEX = 0
) (
    input  logic                       clk,
    input  irst_pkg::cell_ctrl_t       ctrl,
    input  logic [IDX_W-1:0]           wpos,
    input  logic [VALUE_BITS-1:0]      push_first,
    input  logic [VALUE_BITS-1:0]      push_last,
    input  logic [VALUE_BITS-1:0]      next_first,
    input  logic [VALUE_BITS-1:0]      next_last,
    output logic [VALUE_BITS-1:0]      run_first,
    output logic [VALUE_BITS-1:0]      run_last
);

    localparam logic [IDX_W-1:0] MY_POS = IDX_W'(CELL_INDEX);

    logic [VALUE_BITS-1:0] first_reg;
    logic [VALUE_BITS-1:0] last_reg;

    // The cell takes the pushed run at the tail position, moves its
    // neighbor's run one place toward the head on a pop, or else keeps its run.
    always_ff @(posedge clk)
    begin
        if (ctrl.push && (wpos == MY_POS))
        begin
            first_reg <= push_first;
            last_reg  <= push_last;
        end
        else if (ctrl.pop)
        begin
            first_reg <= next_first;
            last_reg  <= next_last;
        end
    end

    assign run_first = first_reg;
    assign run_last  = last_reg;

endmodule

// ----- sim/tb_integer_range_set_table.sv -----
// Self-checking testbench for the integer range set table.
//
// A generator fills a short queue of pending commands. The command driver
// offers them on the cmd channel, and at each accepted transfer it runs the
// local table predictor and queues the expected response. The response
// monitor compares every accepted transfer on res against the oldest
// expected response, one field at a time.
//
// The stimulus opens with directed commands: empty table, bad operation,
// begin above end, runs at both ends of the value range, adjacent merges,
// a table filled to capacity, inserts that still fit in a full table, and
// a rejected insert. A long random part follows. Its inserts are chosen from
// the predictor's current table, so that runs touch, overlap, bridge and
// overflow the table often. The run closes with an insert of the whole
// value range, followed by a query and a read.
module tb_integer_range_set_table;

    timeunit 1ns;
    timeprecision 1ps;

    import irst_pkg::*;

    localparam int TABLE_DEPTH = 16;
    localparam int VALUE_MAX = 65535;
    localparam int RANDOM_ITEMS = 1220;
    localparam int TOTAL_ITEMS = RANDOM_ITEMS + 30;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES = 400;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic clk;
    logic rst_n;

    irst_chan_if #(.payload_t(cmd_t)) cmd_ch ();
    irst_chan_if #(.payload_t(rsp_t)) res_ch ();

    integer_range_set_table DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    // Predicted contents of the table: ascending runs, their count and the
    // number of values that they cover.
    logic [FIELD_W-1:0] span_lo [TABLE_DEPTH];
    logic [FIELD_W-1:0] span_hi [TABLE_DEPTH];
    int                 span_count;
    int                 covered_values;

    cmd_t pending_cmds [$];
    rsp_t expected_rsps [$];

    int error_count;
    int issued_count;
    int results_seen;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    logic hold_armed;
    int idle_cycles;

    always #5 clk = ~clk;

    // One line per problem; the final verdict only looks at the count.
    task automatic report_error(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [16:0] got, logic [16:0] want);
        if (got !== want)
        begin
            report_error($sformatf("result %0d field %s: got %0d, expected %0d",
                                   results_seen, name, got, want));
        end
    endtask

    // Adds the run lo..hi to the predicted table. The new table is built
    // aside: runs wholly below pass through, runs that overlap or touch the
    // new run are absorbed into it, runs wholly above follow. The table is
    // replaced only when the result fits.
    function automatic status_t merge_span(logic [FIELD_W-1:0] lo, logic [FIELD_W-1:0] hi);
        logic [FIELD_W-1:0] next_lo [TABLE_DEPTH+1];
        logic [FIELD_W-1:0] next_hi [TABLE_DEPTH+1];
        logic [FIELD_W-1:0] merged_lo;
        logic [FIELD_W-1:0] merged_hi;
        int n;
        int i;
        int sum;

        if (lo > hi)
        begin
            return ST_ORDER;
        end
        n = 0;
        i = 0;
        merged_lo = lo;
        merged_hi = hi;
        while (i < span_count && int'(span_hi[i]) + 1 < int'(lo))
        begin
            next_lo[n] = span_lo[i];
            next_hi[n] = span_hi[i];
            n++;
            i++;
        end
        while (i < span_count && int'(span_lo[i]) <= int'(hi) + 1)
        begin
            if (span_lo[i] < merged_lo)
            begin
                merged_lo = span_lo[i];
            end
            if (span_hi[i] > merged_hi)
            begin
                merged_hi = span_hi[i];
            end
            i++;
        end
        next_lo[n] = merged_lo;
        next_hi[n] = merged_hi;
        n++;
        while (i < span_count)
        begin
            next_lo[n] = span_lo[i];
            next_hi[n] = span_hi[i];
            n++;
            i++;
        end
        if (n > TABLE_DEPTH)
        begin
            return ST_FULL;
        end
        sum = 0;
        for (i = 0; i < n; i++)
        begin
            span_lo[i] = next_lo[i];
            span_hi[i] = next_hi[i];
            sum += int'(next_hi[i]) - int'(next_lo[i]) + 1;
        end
        span_count = n;
        covered_values = sum;
        return ST_OK;
    endfunction

    // Expected response to one accepted command; updates the predicted table.
    function automatic rsp_t predict_response(cmd_t c);
        rsp_t r;
        int k;

        r = '0;
        r.status = ST_OK;
        case (c.operation)
            OP_INSERT:
            begin
                r.status = merge_span(c.insert_begin, c.insert_end);
            end
            OP_QUERY:
            begin
                for (k = 0; k < span_count; k++)
                begin
                    if (c.query_value >= span_lo[k] && c.query_value <= span_hi[k])
                    begin
                        r.hit = 1'b1;
                    end
                end
            end
            OP_READ:
            begin
                if (int'(c.entry_index) < span_count)
                begin
                    r.entry_begin = span_lo[c.entry_index];
                    r.entry_end = span_hi[c.entry_index];
                end
                else
                begin
                    r.status = ST_INDEX;
                end
            end
            default:
            begin
            end
        endcase
        r.range_count = COUNT_W'(span_count);
        r.total_size = TOTAL_W'(covered_values);
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] clamp_value(int v);
        if (v < 0)
        begin
            return '0;
        end
        if (v > VALUE_MAX)
        begin
            return '1;
        end
        return FIELD_W'(v);
    endfunction

    function automatic cmd_t make_cmd(logic [1:0] op, int lo, int hi, int val, int idx);
        cmd_t c;

        c.operation = op;
        c.insert_begin = clamp_value(lo);
        c.insert_end = clamp_value(hi);
        c.query_value = clamp_value(val);
        c.entry_index = INDEX_FIELD_W'(idx);
        return c;
    endfunction

    // Hands one command to the driver. Pushes happen on the falling edge so
    // that the driver never races the generator. The idle profile follows
    // the position in the run: sender idles lightly and receiver heavily,
    // then the other way round, then neither idles.
    task automatic issue(cmd_t c);
        @(negedge clk);
        while (pending_cmds.size() >= 2)
        begin
            @(negedge clk);
        end
        if (issued_count < TOTAL_ITEMS / 3)
        begin
            send_idle_pct = 22;
            recv_idle_pct = 71;
        end
        else if (issued_count < 2 * TOTAL_ITEMS / 3)
        begin
            send_idle_pct = 71;
            recv_idle_pct = 22;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        pending_cmds.insert(pending_cmds.size(), c);
        issued_count++;
    endtask

    // Returns once every command has been transferred and answered.
    task automatic wait_drained();
        while (pending_cmds.size() != 0 || cmd_ch.valid || expected_rsps.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // One random command. Inserts lean on the current predicted table so that
    // most of them touch, overlap or bridge stored runs instead of landing
    // in empty space and bouncing off a full table.
    task automatic issue_random();
        int cnt;
        int j;
        int pick;
        int lo;
        int hi;
        int gap;
        int val;

        cnt = span_count;
        j = (cnt > 0) ? $urandom_range(cnt - 1) : 0;
        pick = $urandom_range(99);
        lo = $urandom_range(VALUE_MAX);
        hi = lo + $urandom_range(15);
        if (pick < 48)
        begin
            pick = $urandom_range(99);
            if (cnt == 0 || pick < 30)
            begin
                // Fresh short run somewhere in the value range.
            end
            else if (pick < 55)
            begin
                // Run that touches a stored run or leaves a gap of one.
                if ($urandom_range(1) == 0)
                begin
                    lo = int'(span_hi[j]) + 1 + $urandom_range(1);
                    hi = lo + $urandom_range(6);
                end
                else
                begin
                    hi = int'(span_lo[j]) - 1 - $urandom_range(1);
                    lo = hi - $urandom_range(6);
                end
            end
            else if (pick < 75 && cnt >= 2)
            begin
                // Bridge to the next run; wide gaps only rarely, so that the
                // covered set grows slowly.
                j = $urandom_range(cnt - 2);
                gap = int'(span_lo[j + 1]) - int'(span_hi[j]);
                if (gap <= 300 || $urandom_range(39) == 0)
                begin
                    lo = $urandom_range(int'(span_hi[j]) + 1, int'(span_lo[j]));
                    hi = int'(span_lo[j + 1]) - 1 + $urandom_range(2);
                end
            end
            else if (pick < 90)
            begin
                // Overlaps or sits inside a stored run.
                lo = int'(span_lo[j]) + $urandom_range(6) - 3;
                hi = int'(span_hi[j]) + $urandom_range(6) - 3;
            end
            else if ($urandom_range(1) == 0)
            begin
                lo = 0;
                hi = $urandom_range(31);
            end
            else
            begin
                lo = VALUE_MAX - $urandom_range(31);
                hi = VALUE_MAX;
            end
            issue(make_cmd(OP_INSERT, lo, hi, $urandom_range(VALUE_MAX), $urandom_range(15)));
        end
        else if (pick < 72)
        begin
            val = $urandom_range(VALUE_MAX);
            if (cnt > 0 && $urandom_range(1) == 0)
            begin
                case ($urandom_range(3))
                    0: val = int'(span_lo[j]) - 1;
                    1: val = int'(span_lo[j]);
                    2: val = int'(span_hi[j]);
                    default: val = int'(span_hi[j]) + 1;
                endcase
                val = val & VALUE_MAX;
            end
            issue(make_cmd(OP_QUERY, $urandom_range(VALUE_MAX), $urandom_range(VALUE_MAX),
                           val, $urandom_range(15)));
        end
        else if (pick < 87)
        begin
            issue(make_cmd(OP_READ, $urandom_range(VALUE_MAX), $urandom_range(VALUE_MAX),
                           $urandom_range(VALUE_MAX), $urandom_range(15)));
        end
        else if (pick < 93)
        begin
            // Begin above end: rejected, table unchanged.
            lo = $urandom_range(VALUE_MAX, 1);
            hi = $urandom_range(lo - 1);
            issue(make_cmd(OP_INSERT, lo, hi, $urandom_range(VALUE_MAX), $urandom_range(15)));
        end
        else
        begin
            issue(make_cmd(OP_UNUSED, $urandom_range(VALUE_MAX), $urandom_range(VALUE_MAX),
                           $urandom_range(VALUE_MAX), $urandom_range(15)));
        end
    endtask

    // Command driver. A transfer happens at an edge with valid and ready both
    // high; the predictor runs on exactly those transfers. A new command is
    // put up only when the channel is free, and valid is assigned at most once
    // per edge so that a held valid never dips.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.payload <= '0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                expected_rsps.insert(expected_rsps.size(), predict_response(cmd_ch.payload));
            end
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cmd_ch.payload <= pending_cmds.pop_front();
                    cmd_ch.valid <= 1'b1;
                end
                else
                begin
                    cmd_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here on its own. It starts once a
    // number of responses have been seen and keeps ready low while the
    // driver goes on offering commands, so that the block backs up and
    // stops taking commands.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_armed <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (hold_armed && results_seen >= 150)
        begin
            hold_left <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end
    end

    // Response receiver: random back-pressure, plus the hold-off above.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Response monitor: each accepted transfer is matched against the oldest
    // expected response, field by field.
    always @(posedge clk)
    begin
        rsp_t want;

        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_seen <= results_seen + 1;
            if (expected_rsps.size() == 0)
            begin
                report_error($sformatf("response %0d arrived with nothing expected",
                                       results_seen));
            end
            else
            begin
                want = expected_rsps.pop_front();
                check_field("hit", 17'(res_ch.payload.hit), 17'(want.hit));
                check_field("entry_begin", 17'(res_ch.payload.entry_begin),
                            17'(want.entry_begin));
                check_field("entry_end", 17'(res_ch.payload.entry_end),
                            17'(want.entry_end));
                check_field("range_count", 17'(res_ch.payload.range_count),
                            17'(want.range_count));
                check_field("total_size", res_ch.payload.total_size, want.total_size);
                check_field("status", 17'(res_ch.payload.status), 17'(want.status));
            end
        end
    end

    // Watchdog: too many cycles without a transfer on either channel means
    // the block has hung.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no transfer for %0d cycles", idle_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        int k;

        clk = 1'b0;
        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.payload = '0;
        res_ch.ready = 1'b0;
        span_lo = '{default: '0};
        span_hi = '{default: '0};
        span_count = 0;
        covered_values = 0;
        error_count = 0;
        issued_count = 0;
        results_seen = 0;
        send_idle_pct = 22;
        recv_idle_pct = 71;
        idle_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Commands on an empty table, the unused operation and a reversed run.
        issue(make_cmd(OP_READ, 0, 0, 0, 0));
        issue(make_cmd(OP_QUERY, 0, 0, 0, 0));
        issue(make_cmd(OP_UNUSED, VALUE_MAX, VALUE_MAX, VALUE_MAX, 15));
        issue(make_cmd(OP_INSERT, VALUE_MAX, 0, 0, 0));

        // Runs at both ends of the value range, then a run that closes a gap
        // of one so that three runs merge through adjacency.
        issue(make_cmd(OP_INSERT, 0, 0, 0, 0));
        issue(make_cmd(OP_INSERT, VALUE_MAX, VALUE_MAX, 0, 0));
        issue(make_cmd(OP_QUERY, 0, 0, VALUE_MAX, 0));
        issue(make_cmd(OP_INSERT, 2, 9, 0, 0));
        issue(make_cmd(OP_INSERT, 1, 1, 0, 0));
        issue(make_cmd(OP_READ, 0, 0, 0, 1));
        issue(make_cmd(OP_READ, 0, 0, 0, 2));

        // Fill the table to capacity.
        for (k = 1; k <= 14; k++)
        begin
            issue(make_cmd(OP_INSERT, 1000 * k, 1000 * k + k, 0, 0));
        end
        issue(make_cmd(OP_READ, 0, 0, 0, 15));

        // Full table: an extension that fits, a new run that does not, and a
        // bridge that merges two runs through adjacency.
        issue(make_cmd(OP_INSERT, 3004, 3010, 0, 0));
        issue(make_cmd(OP_INSERT, 500, 600, 0, 0));
        issue(make_cmd(OP_INSERT, 1002, 1999, 0, 0));
        issue(make_cmd(OP_QUERY, 0, 0, 500, 0));
        issue(make_cmd(OP_READ, 0, 0, 0, 15));

        for (k = 0; k < RANDOM_ITEMS - 3; k++)
        begin
            if (k == RANDOM_ITEMS / 2)
            begin
                // Sender pause: let the block run completely dry once.
                wait_drained();
            end
            issue_random();
        end

        // The whole value range as one run: widest total and a single run.
        issue(make_cmd(OP_INSERT, 0, VALUE_MAX, 0, 0));
        issue(make_cmd(OP_QUERY, 0, 0, $urandom_range(VALUE_MAX), 0));
        issue(make_cmd(OP_READ, 0, 0, 0, 0));

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
